>>> rtl/rcdc_pkg.sv
// Shared types and widths for the romanized Cyrillic to display code unit.
`default_nettype none
package rcdc_pkg;

	localparam int CharW  = 8;
	localparam int GlyphW = 8;
	localparam int PosW   = 8;
	localparam int CountW = 2;

	// configuration register indexes
	localparam logic RegStartPos    = 1'b0;
	localparam logic RegReplacement = 1'b1;

	typedef enum logic [2:0] {
		PFX_NONE,
		PFX_Z,
		PFX_K,
		PFX_C,
		PFX_E,
		PFX_J,
		PFX_S,
		PFX_SH
	} prefix_t;

	// Glyphs produced by one character, in emission order
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [GlyphW-1:0] glyph0;
		logic [GlyphW-1:0] glyph1;
		prefix_t           next_prefix;
	} decode_t;

	// One character's worth of results, ready for the output register
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [GlyphW-1:0] glyph0;
		logic [GlyphW-1:0] glyph1;
		logic [PosW-1:0]   pos0;
		logic [PosW-1:0]   pos1;
		logic              last;
	} load_t;

endpackage
`default_nettype wire

>>> rtl/rcdc_decode.sv
// Digraph recognition and glyph table lookup for one character.
`default_nettype none
module rcdc_decode (
	input  rcdc_pkg::prefix_t            prefix,
	input  logic [rcdc_pkg::CharW-1:0]   character,
	input  logic                         end_flag,
	input  logic [rcdc_pkg::GlyphW-1:0]  replacement,
	output rcdc_pkg::decode_t            dec
);

	localparam logic [7:0] GlyphZh  = 8'h09;
	localparam logic [7:0] GlyphKh  = 8'h17;
	localparam logic [7:0] GlyphCh  = 8'h01;
	localparam logic [7:0] GlyphEh  = 8'h03;
	localparam logic [7:0] GlyphJu  = 8'h1F;
	localparam logic [7:0] GlyphJa  = 8'h0E;
	localparam logic [7:0] GlyphSh  = 8'h04;
	localparam logic [7:0] GlyphShh = 8'h02;
	localparam logic [7:0] GlyphZ   = 8'h05;
	localparam logic [7:0] GlyphK   = 8'h14;
	localparam logic [7:0] GlyphC   = 8'h1C;
	localparam logic [7:0] GlyphE   = 8'h1A;
	localparam logic [7:0] GlyphJ   = 8'h15;
	localparam logic [7:0] GlyphS   = 8'h0C;
	localparam logic [7:0] GlyphQuote = 8'h07;

	// A..Z, zero where the display has no glyph
	function automatic logic [7:0] letter_glyph(input logic [4:0] idx);
		logic [7:0] g;
		unique case (idx)
			5'd0:    g = 8'h1E;
			5'd1:    g = 8'h1D;
			5'd2:    g = 8'h1C;
			5'd3:    g = 8'h1B;
			5'd4:    g = 8'h1A;
			5'd5:    g = 8'h19;
			5'd6:    g = 8'h18;
			5'd8:    g = 8'h16;
			5'd9:    g = 8'h15;
			5'd10:   g = 8'h14;
			5'd11:   g = 8'h13;
			5'd12:   g = 8'h12;
			5'd13:   g = 8'h11;
			5'd14:   g = 8'h10;
			5'd15:   g = 8'h0F;
			5'd17:   g = 8'h0D;
			5'd18:   g = 8'h0C;
			5'd19:   g = 8'h0B;
			5'd20:   g = 8'h0A;
			5'd21:   g = 8'h08;
			5'd24:   g = 8'h06;
			5'd25:   g = 8'h05;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] char_glyph(input logic [7:0] c, input logic [7:0] repl);
		logic [7:0] g;
		logic [7:0] lg;
		logic [7:0] offs;
		offs = c - 8'h41;
		lg   = letter_glyph(offs[4:0]);
		priority if (c >= 8'h41 && c <= 8'h5A) begin
			g = (lg != 8'h00) ? lg : repl;
		end else if (c == 8'h22 || c == 8'h27) begin
			g = GlyphQuote;
		end else if (c <= 8'h40) begin
			g = 8'd127 - c;
		end else begin
			unique case (c)
				8'd91:   g = 8'h24;
				8'd92:   g = 8'h23;
				8'd93:   g = 8'h22;
				8'd94:   g = 8'h21;
				8'd95:   g = 8'h20;
				8'd96:   g = 8'h58;
				default: g = repl;
			endcase
		end
		return g;
	endfunction

	function automatic rcdc_pkg::prefix_t prefix_of(input logic [7:0] c);
		rcdc_pkg::prefix_t p;
		unique case (c)
			8'h5A:   p = rcdc_pkg::PFX_Z;
			8'h4B:   p = rcdc_pkg::PFX_K;
			8'h43:   p = rcdc_pkg::PFX_C;
			8'h45:   p = rcdc_pkg::PFX_E;
			8'h4A:   p = rcdc_pkg::PFX_J;
			8'h53:   p = rcdc_pkg::PFX_S;
			default: p = rcdc_pkg::PFX_NONE;
		endcase
		return p;
	endfunction

	logic              is_h;
	logic              is_u;
	logic              is_a;
	logic              lead_valid;
	logic [7:0]        lead_glyph;
	logic              fresh;
	logic              tail_valid;
	logic [7:0]        tail_glyph;
	rcdc_pkg::prefix_t new_prefix;
	rcdc_pkg::prefix_t next_prefix;

	assign is_h = (character == 8'h48);
	assign is_u = (character == 8'h55);
	assign is_a = (character == 8'h41);
	assign new_prefix = prefix_of(character);

	always_comb begin
		lead_valid  = 1'b0;
		lead_glyph  = 8'h00;
		fresh       = 1'b0;
		tail_valid  = 1'b0;
		tail_glyph  = 8'h00;
		next_prefix = rcdc_pkg::PFX_NONE;

		// a broken digraph gives its prefix letter first
		unique case (prefix)
			rcdc_pkg::PFX_NONE: begin
				fresh = 1'b1;
			end
			rcdc_pkg::PFX_Z: begin
				lead_valid = 1'b1;
				lead_glyph = is_h ? GlyphZh : GlyphZ;
				fresh      = !is_h;
			end
			rcdc_pkg::PFX_K: begin
				lead_valid = 1'b1;
				lead_glyph = is_h ? GlyphKh : GlyphK;
				fresh      = !is_h;
			end
			rcdc_pkg::PFX_C: begin
				lead_valid = 1'b1;
				lead_glyph = is_h ? GlyphCh : GlyphC;
				fresh      = !is_h;
			end
			rcdc_pkg::PFX_E: begin
				lead_valid = 1'b1;
				lead_glyph = is_h ? GlyphEh : GlyphE;
				fresh      = !is_h;
			end
			rcdc_pkg::PFX_J: begin
				lead_valid = 1'b1;
				lead_glyph = is_u ? GlyphJu : (is_a ? GlyphJa : GlyphJ);
				fresh      = !(is_u || is_a);
			end
			rcdc_pkg::PFX_S: begin
				if (is_h) begin
					// SH waits for a possible third letter unless the string ends
					lead_valid = end_flag;
					lead_glyph = GlyphSh;
					if (!end_flag) begin
						next_prefix = rcdc_pkg::PFX_SH;
					end
				end else begin
					lead_valid = 1'b1;
					lead_glyph = GlyphS;
					fresh      = 1'b1;
				end
			end
			rcdc_pkg::PFX_SH: begin
				lead_valid = 1'b1;
				lead_glyph = is_h ? GlyphShh : GlyphSh;
				fresh      = !is_h;
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			if (new_prefix != rcdc_pkg::PFX_NONE && !end_flag) begin
				next_prefix = new_prefix;
			end else begin
				tail_valid = 1'b1;
				tail_glyph = char_glyph(character, replacement);
			end
		end

		dec.next_prefix = next_prefix;
		if (lead_valid) begin
			dec.count  = tail_valid ? 2'd2 : 2'd1;
			dec.glyph0 = lead_glyph;
			dec.glyph1 = tail_glyph;
		end else begin
			dec.count  = tail_valid ? 2'd1 : 2'd0;
			dec.glyph0 = tail_glyph;
			dec.glyph1 = 8'h00;
		end
	end

endmodule
`default_nettype wire

>>> rtl/rcdc_outbuf.sv
// Result register: holds up to two glyph items and hands them out one per cycle while m_tready is high.
`default_nettype none
module rcdc_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_en,
	input  rcdc_pkg::load_t        load,
	output logic                   can_load,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // position [7:0], glyph_code [15:8]
	output logic                   m_tlast    // end_of_text
);

	logic [rcdc_pkg::CountW-1:0] rem_q;
	logic                        hd_q;
	logic [rcdc_pkg::PosW-1:0]   pos_q   [2];
	logic [rcdc_pkg::GlyphW-1:0] glyph_q [2];
	logic                        last_q;
	logic                        take;

	assign m_tvalid = (rem_q != 2'd0);
	assign take     = m_tvalid && m_tready;
	assign can_load = (rem_q == 2'd0) || (rem_q == 2'd1 && m_tready);
	assign m_tdata  = {glyph_q[hd_q], pos_q[hd_q]};
	assign m_tlast  = last_q && (rem_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			hd_q  <= 1'b0;
		end else if (load_en) begin
			rem_q <= load.count;
			hd_q  <= 1'b0;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
			hd_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			pos_q[0]   <= load.pos0;
			pos_q[1]   <= load.pos1;
			glyph_q[0] <= load.glyph0;
			glyph_q[1] <= load.glyph1;
			last_q     <= load.last;
		end
	end

endmodule
`default_nettype wire

>>> rtl/romanized_cyrillic_to_display_code_unit.sv
// Romanized Cyrillic to display glyph codes: top level.
// Takes one byte of capital romanized Cyrillic per item on the s_ side
// (s_tlast marks the last byte of a string) and gives one item per glyph on
// the m_ side: the glyph code and the screen position it goes to, with m_tlast
// on the last glyph of the string. ZH, KH, CH, EH, JU, JA, SH and SHH are
// recognised by holding the prefix letter back, so a byte yields zero, one or
// two glyphs. A byte is registered, decoded in the next cycle and its glyphs
// land in a two-entry result register, which hands out one glyph per cycle
// while m_tready is high; the first glyph of a byte is presented from the
// result register once the decoded byte has been loaded there.
// The cursor wraps at SCREEN_SIZE. Writing start_position (index 0) loads the
// cursor, values of SCREEN_SIZE or more load 0; replacement_code (index 1,
// reset 35) is sent for bytes the table does not cover. Write registers only
// while no text is in flight.
`default_nettype none
module romanized_cyrillic_to_display_code_unit #(
	parameter int SCREEN_SIZE = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // character [7:0]
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // position [7:0], glyph_code [15:8]
	output logic        m_tlast,   // end_of_text
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int          PosW      = rcdc_pkg::PosW;
	localparam logic [PosW:0] ScreenLim = (PosW+1)'(SCREEN_SIZE);

	function automatic logic [PosW-1:0] wrap_inc(input logic [PosW-1:0] p);
		logic [PosW:0] n;
		n = {1'b0, p} + 1'b1;
		return (n >= ScreenLim) ? '0 : n[PosW-1:0];
	endfunction

	logic                         valid_s1;
	logic [rcdc_pkg::CharW-1:0]   char_s1;
	logic                         end_s1;
	logic [PosW-1:0]              cursor_q;
	rcdc_pkg::prefix_t            prefix_q;
	logic [rcdc_pkg::GlyphW-1:0]  repl_q;
	rcdc_pkg::decode_t            dec;
	rcdc_pkg::load_t              load;
	logic                         can_load;
	logic                         move;
	logic [PosW-1:0]              pos1;
	logic [PosW-1:0]              pos2;

	assign move     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	rcdc_decode u_decode (
		.prefix      (prefix_q),
		.character   (char_s1),
		.end_flag    (end_s1),
		.replacement (repl_q),
		.dec         (dec)
	);

	assign pos1 = wrap_inc(cursor_q);
	assign pos2 = wrap_inc(pos1);

	always_comb begin
		load.count  = dec.count;
		load.glyph0 = dec.glyph0;
		load.glyph1 = dec.glyph1;
		load.pos0   = cursor_q;
		load.pos1   = pos1;
		load.last   = end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			prefix_q <= rcdc_pkg::PFX_NONE;
			repl_q   <= 8'd35;
		end else begin
			if (cfg_we && cfg_index == rcdc_pkg::RegStartPos) begin
				cursor_q <= ({1'b0, cfg_data} >= ScreenLim) ? '0 : cfg_data;
			end else if (move) begin
				unique case (dec.count)
					2'd0:    cursor_q <= cursor_q;
					2'd1:    cursor_q <= pos1;
					default: cursor_q <= pos2;
				endcase
			end
			if (cfg_we && cfg_index == rcdc_pkg::RegReplacement) begin
				repl_q <= cfg_data;
			end
			if (move) begin
				prefix_q <= dec.next_prefix;
			end
		end
	end

	rcdc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (move),
		.load     (load),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

>>> test/tb_romanized_cyrillic_to_display_code_unit.sv
// Self-checking testbench for the romanized Cyrillic to display code unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_romanized_cyrillic_to_display_code_unit;

	localparam int SCREEN_SIZE  = 160;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam longint TIMEOUT_NS = 64'd20_000_000;

	localparam logic [7:0] DEFAULT_REPL = 8'd35;

	// digraph, trigraph and quote glyphs
	localparam logic [7:0] GL_ZH    = 8'h09;
	localparam logic [7:0] GL_KH    = 8'h17;
	localparam logic [7:0] GL_CH    = 8'h01;
	localparam logic [7:0] GL_EH    = 8'h03;
	localparam logic [7:0] GL_JU    = 8'h1F;
	localparam logic [7:0] GL_JA    = 8'h0E;
	localparam logic [7:0] GL_SH    = 8'h04;
	localparam logic [7:0] GL_SHH   = 8'h02;
	localparam logic [7:0] GL_QUOTE = 8'h07;

	localparam logic [7:0] PUNCT_FIRST = 8'd91;
	localparam logic [7:0] PUNCT_LAST  = 8'd96;
	localparam logic [7:0] MIRROR_TOP  = 8'd64;
	localparam logic [7:0] MIRROR_BASE = 8'd127;

	// A..Z; zero marks a letter with no glyph of its own
	localparam logic [0:25][7:0] LETTER_GLYPH = {
		8'h1E, 8'h1D, 8'h1C, 8'h1B, 8'h1A, 8'h19, 8'h18, 8'h00, 8'h16, 8'h15, 8'h14,
		8'h13, 8'h12, 8'h11, 8'h10, 8'h0F, 8'h00, 8'h0D, 8'h0C, 8'h0B, 8'h0A, 8'h08,
		8'h00, 8'h00, 8'h06, 8'h05
	};
	// [ \ ] ^ _ `
	localparam logic [0:5][7:0] PUNCT_GLYPH = {8'h24, 8'h23, 8'h22, 8'h21, 8'h20, 8'h58};

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
		logic       typed;   // g0/g1 give the glyphs by hand
		logic [7:0] g0;
		logic [7:0] g1;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] pos;
		logic [7:0] glyph;
		logic       last;
	} glyph_item_t;

	localparam int NUM_DIRECTED = 27;
	localparam stim_row_t [0:NUM_DIRECTED-1] DIRECTED_ROWS = {
		{"Z",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b1, GL_ZH, 8'h00},
		{"K",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b1, GL_KH, 8'h00},
		{"C",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b1, GL_CH, 8'h00},
		{"E",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b1, GL_EH, 8'h00},
		{"J",   1'b0, 1'b0, 8'h00, 8'h00},
		{"U",   1'b0, 1'b1, GL_JU, 8'h00},
		{"J",   1'b0, 1'b0, 8'h00, 8'h00},
		{"A",   1'b0, 1'b1, GL_JA, 8'h00},
		{"S",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b1, GL_SHH, 8'h00},
		{"S",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b0, 1'b0, 8'h00, 8'h00},
		{"B",   1'b0, 1'b1, GL_SH, 8'h1D},        // SH then a plain letter
		{"Z",   1'b0, 1'b0, 8'h00, 8'h00},
		{"B",   1'b0, 1'b1, 8'h05, 8'h1D},        // broken digraph
		{"Q",   1'b0, 1'b1, DEFAULT_REPL, 8'h00},
		{8'h00, 1'b0, 1'b1, 8'h7F, 8'h00},
		{8'hFF, 1'b0, 1'b1, DEFAULT_REPL, 8'h00},
		{8'h27, 1'b0, 1'b1, GL_QUOTE, 8'h00},
		{"S",   1'b1, 1'b1, 8'h0C, 8'h00},        // prefix letter with end flag
		{"S",   1'b0, 1'b0, 8'h00, 8'h00},
		{"H",   1'b1, 1'b1, GL_SH, 8'h00}         // SH flushed at end
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// predictor state
	rcdc_pkg::prefix_t held_prefix;
	logic [7:0]        cursor_pos;
	logic [7:0]        repl_glyph;

	glyph_item_t glyph_queue[$];

	int  mismatch_count;
	int  items_sent;
	int  glyphs_checked;
	int  cfg_writes;
	int  input_stalls;
	bit  steady;
	bit  hold_request;

	romanized_cyrillic_to_display_code_unit #(
		.SCREEN_SIZE(SCREEN_SIZE)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [7:0] glyph_of(input logic [7:0] c);
		logic [7:0] g;
		if (c >= "A" && c <= "Z") begin
			g = LETTER_GLYPH[c - "A"];
			return (g != 8'h00) ? g : repl_glyph;
		end
		if (c == 8'h22 || c == 8'h27)
			return GL_QUOTE;
		if (c <= MIRROR_TOP)
			return MIRROR_BASE - c;
		if (c >= PUNCT_FIRST && c <= PUNCT_LAST)
			return PUNCT_GLYPH[c - PUNCT_FIRST];
		return repl_glyph;
	endfunction

	function automatic rcdc_pkg::prefix_t prefix_for(input logic [7:0] c);
		case (c)
			"Z": return rcdc_pkg::PFX_Z;
			"K": return rcdc_pkg::PFX_K;
			"C": return rcdc_pkg::PFX_C;
			"E": return rcdc_pkg::PFX_E;
			"J": return rcdc_pkg::PFX_J;
			"S": return rcdc_pkg::PFX_S;
			default: return rcdc_pkg::PFX_NONE;
		endcase
	endfunction

	function automatic logic [7:0] letter_of(input rcdc_pkg::prefix_t p);
		case (p)
			rcdc_pkg::PFX_Z: return "Z";
			rcdc_pkg::PFX_K: return "K";
			rcdc_pkg::PFX_C: return "C";
			rcdc_pkg::PFX_E: return "E";
			rcdc_pkg::PFX_J: return "J";
			default: return "S";
		endcase
	endfunction

	// Works out the glyphs one character gives and queues them with their positions.
	task automatic decode_char(input stim_row_t row);
		rcdc_pkg::prefix_t p;
		rcdc_pkg::prefix_t q;
		bit                fresh;
		int                n;
		logic [7:0]        gl [2];
		glyph_item_t       it;
		p = held_prefix;
		held_prefix = rcdc_pkg::PFX_NONE;
		fresh = 1'b1;
		n = 0;
		if (p != rcdc_pkg::PFX_NONE) begin
			fresh = 1'b0;
			case (p)
				rcdc_pkg::PFX_Z, rcdc_pkg::PFX_K, rcdc_pkg::PFX_C, rcdc_pkg::PFX_E: begin
					if (row.ch == "H") begin
						gl[n] = (p == rcdc_pkg::PFX_Z) ? GL_ZH :
							(p == rcdc_pkg::PFX_K) ? GL_KH :
							(p == rcdc_pkg::PFX_C) ? GL_CH : GL_EH;
						n++;
					end else
						fresh = 1'b1;
				end
				rcdc_pkg::PFX_J: begin
					if (row.ch == "U") begin
						gl[n] = GL_JU; n++;
					end else if (row.ch == "A") begin
						gl[n] = GL_JA; n++;
					end else
						fresh = 1'b1;
				end
				rcdc_pkg::PFX_S: begin
					if (row.ch == "H") begin
						if (row.eos) begin
							gl[n] = GL_SH; n++;
						end else
							held_prefix = rcdc_pkg::PFX_SH;
					end else
						fresh = 1'b1;
				end
				default: begin
					if (row.ch == "H") begin
						gl[n] = GL_SHH; n++;
					end else begin
						gl[n] = GL_SH; n++;
						fresh = 1'b1;
						p = rcdc_pkg::PFX_NONE;
					end
				end
			endcase
			if (fresh && p != rcdc_pkg::PFX_NONE) begin
				gl[n] = glyph_of(letter_of(p)); n++;
			end
		end
		if (fresh) begin
			q = prefix_for(row.ch);
			if (q != rcdc_pkg::PFX_NONE && !row.eos)
				held_prefix = q;
			else begin
				gl[n] = glyph_of(row.ch); n++;
			end
		end
		if (row.typed) begin
			gl[0] = row.g0;
			gl[1] = row.g1;
		end
		for (int i = 0; i < n; i++) begin
			it.pos   = cursor_pos;
			it.glyph = gl[i];
			it.last  = row.eos && (i == n - 1);
			glyph_queue.push_back(it);
			cursor_pos = (cursor_pos + 1 >= SCREEN_SIZE) ? 8'd0 : cursor_pos + 8'd1;
		end
	endtask

	task automatic send_char(input stim_row_t row);
		int r;
		int gap;
		r = $urandom_range(0, 9);
		if (steady || hold_request)
			gap = 0;
		else if (r < 6)
			gap = 0;
		else if (r < 9)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= row.ch;
		s_tlast  <= row.eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_char(row);
		items_sent++;
	endtask

	// Lowers the input and waits for every queued glyph to come out.
	task automatic drain_glyphs();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (glyph_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rcdc_pkg::RegStartPos)
			cursor_pos = (value >= SCREEN_SIZE) ? 8'd0 : value;
		else
			repl_glyph = value;
		cfg_writes++;
	endtask

	// Mostly prefix letters and their completers so digraphs come up often.
	function automatic logic [7:0] word_char();
		int r;
		logic [7:0] hot [9];
		hot = '{"Z", "K", "C", "E", "J", "S", "H", "U", "A"};
		r = $urandom_range(0, 99);
		if (r < 40)
			return hot[$urandom_range(0, 8)];
		if (r < 75)
			return 8'("A" + $urandom_range(0, 25));
		if (r < 85)
			return 8'($urandom_range(32, 96));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_items(input int count);
		int sent;
		int len;
		stim_row_t row;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				row = {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
					8'h00, 8'h00};
				send_char(row);
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					row = {word_char(), 1'b0, 1'b0, 8'h00, 8'h00};
					row.eos = (i == len - 1) && ($urandom_range(0, 2) == 0);
					send_char(row);
				end
				sent += len;
			end
		end
	endtask

	// Sink side: random stalls, and a long hold-off on request.
	initial begin
		int n;
		int r;
		int stall;
		m_tready = 1'b0;
		forever begin
			if (hold_request) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				hold_request = 1'b0;
			end
			n = $urandom_range(1, 30);
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
			r = $urandom_range(0, 9);
			if (steady)
				stall = 0;
			else if (r < 7)
				stall = $urandom_range(1, 3);
			else if (r < 9)
				stall = $urandom_range(4, 10);
			else
				stall = $urandom_range(20, 60);
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		glyph_item_t exp_item;
		if (arst_n && s_tvalid && !s_tready)
			input_stalls++;
		if (arst_n && m_tvalid && m_tready) begin
			glyphs_checked++;
			if (glyph_queue.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected glyph pos=%0d code=%h last=%b", $time,
					m_tdata[7:0], m_tdata[15:8], m_tlast);
			end else begin
				exp_item = glyph_queue.pop_front();
				if (m_tdata[7:0] !== exp_item.pos) begin
					mismatch_count++;
					$display("%0t: position expected %0d actual %0d", $time,
						exp_item.pos, m_tdata[7:0]);
				end
				if (m_tdata[15:8] !== exp_item.glyph) begin
					mismatch_count++;
					$display("%0t: glyph_code expected %h actual %h", $time,
						exp_item.glyph, m_tdata[15:8]);
				end
				if (m_tlast !== exp_item.last) begin
					mismatch_count++;
					$display("%0t: end_of_text expected %b actual %b", $time,
						exp_item.last, m_tlast);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout, %0d glyphs still expected", $time, glyph_queue.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [7:0] start_val;
		logic [7:0] repl_val;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = rcdc_pkg::RegStartPos;
		cfg_data  = 8'h00;
		steady       = 1'b0;
		hold_request = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		glyphs_checked = 0;
		cfg_writes     = 0;
		input_stalls   = 0;
		held_prefix = rcdc_pkg::PFX_NONE;
		cursor_pos  = 8'd0;
		repl_glyph  = DEFAULT_REPL;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_char(DIRECTED_ROWS[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_glyphs();
			// a held prefix gives no glyph, so let the block settle
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (ph)
				0: begin start_val = 8'(SCREEN_SIZE - 1); repl_val = 8'h00; end
				1: begin start_val = 8'd200;              repl_val = 8'hFF; end
				2: begin start_val = 8'hFF; repl_val = 8'($urandom_range(0, 255)); end
				3: begin start_val = 8'h00; repl_val = 8'($urandom_range(0, 255)); end
				default: begin
					start_val = 8'($urandom_range(0, 255));
					repl_val  = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(rcdc_pkg::RegStartPos, start_val);
			write_reg(rcdc_pkg::RegReplacement, repl_val);
			steady = (ph == 2);
			if (ph == 1)
				hold_request = 1'b1;
			if (ph == 3) begin
				send_random_items(PHASE_ITEMS / 2);
				drain_glyphs();
				send_random_items(PHASE_ITEMS / 2);
			end else
				send_random_items(PHASE_ITEMS);
		end
		steady = 1'b0;

		drain_glyphs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d characters through %0d register writes; checked %0d glyphs.",
			items_sent, cfg_writes, glyphs_checked);
		$display("Input was held back for %0d cycles by output stalls.", input_stalls);
		if (mismatch_count == 0 && glyph_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/rcdc_pkg.sv
rtl/rcdc_decode.sv
rtl/rcdc_outbuf.sv
rtl/romanized_cyrillic_to_display_code_unit.sv
test/tb_romanized_cyrillic_to_display_code_unit.sv
